[rtl/mesh_volume_centroid_defines.svh]
// mesh_volume_centroid_defines.svh: assertion macros shared by the mesh volume rtl
// expects signals named clock and reset in the module that uses them
`ifndef MESH_VOLUME_CENTROID_DEFINES_SVH
`define MESH_VOLUME_CENTROID_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define MVC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define MVC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/mvc_pkg.sv]
// mvc_pkg: widths, constants and the queue entry type of the mesh volume block
// no dependencies; imported by every module of the block
package mvc_pkg;

   // default configuration
   localparam int MVC_COORD_BITS  = 10;
   localparam int MVC_QUEUE_DEPTH = 4;

   // field counts and fixed result widths
   localparam int NUM_COORDS = 9;
   localparam int NUM_AXES   = 3;
   localparam int AXIS_W     = 2;
   localparam int VOL_BITS   = 48;
   localparam int MOM_BITS   = 60;
   localparam int CEN_BITS   = 18;
   localparam int THR_BITS   = 20;

   // centroid = s * 2^FRAC_SHIFT / t; quotient has CEN_BITS bits at most
   localparam int FRAC_SHIFT = 5;
   localparam int QSHIFT     = CEN_BITS - FRAC_SHIFT;
   localparam int STEP_W     = $clog2(CEN_BITS);

   // result bus layout
   localparam int OUT_FIELD_W = VOL_BITS + NUM_AXES * CEN_BITS;
   localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

   localparam logic [AXIS_W-1:0]   AXIS_LAST = AXIS_W'(NUM_AXES - 1);
   localparam logic [CEN_BITS-1:0] CEN_MAX   = {1'b0, {(CEN_BITS-1){1'b1}}};
   localparam logic [CEN_BITS-1:0] CEN_MIN   = {1'b1, {(CEN_BITS-1){1'b0}}};

   // per-triangle contributions passed from front to back
   typedef struct packed {
      logic                                   last;
      logic [NUM_AXES-1:0][MOM_BITS-1:0]      mom;
      logic [VOL_BITS-1:0]                    vol;
   } term_type;

endpackage

[rtl/mvc_front.sv]
// mvc_front: five-stage pipeline turning a triangle into volume and moment terms
// depends on mvc_pkg; feeds mvc_fifo
module mvc_front #(
   parameter int COORD_BITS = mvc_pkg::MVC_COORD_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from the lowest bit up
   input  logic [((mvc_pkg::NUM_COORDS*COORD_BITS+7)/8)*8-1:0] req_tdata,
   input  logic                     req_tlast,
   input  logic                     q_full,
   output logic                     q_push,
   output mvc_pkg::term_type        q_term
);
   import mvc_pkg::*;

   localparam int CB  = COORD_BITS;
   localparam int E   = CB + 1;      // edges and vertex pair sums
   localparam int PW  = 2 * E;       // products and squares
   localparam int NW  = PW + 1;      // face vector
   localparam int SW  = PW + 1;      // sum of three squares
   localparam int VW  = CB + NW;     // a_i * n_i
   localparam int VSW = VW + 2;      // sum of three
   localparam int MW  = NW + SW;     // n_i * sq_i

   // signed E x E product at full width
   function automatic logic signed [PW-1:0] emul(input logic [E-1:0] x, input logic [E-1:0] y);
      logic signed [PW-1:0] xw;
      logic signed [PW-1:0] yw;
      xw = $signed({{E{x[E-1]}}, x});
      yw = $signed({{E{y[E-1]}}, y});
      return xw * yw;
   endfunction

   logic                 adv;
   logic [CB-1:0]        crd_a [NUM_AXES];
   logic [CB-1:0]        crd_b [NUM_AXES];
   logic [CB-1:0]        crd_c [NUM_AXES];

   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_last_ff;
   logic [CB-1:0]        s1_a_ff  [NUM_AXES];
   logic [E-1:0]         s1_e1_ff [NUM_AXES], s1_e1_in [NUM_AXES];
   logic [E-1:0]         s1_e2_ff [NUM_AXES], s1_e2_in [NUM_AXES];
   logic [E-1:0]         s1_p_ff  [NUM_AXES], s1_p_in  [NUM_AXES];
   logic [E-1:0]         s1_q_ff  [NUM_AXES], s1_q_in  [NUM_AXES];
   logic [E-1:0]         s1_r_ff  [NUM_AXES], s1_r_in  [NUM_AXES];

   logic                 s2_valid_ff;
   logic                 s2_last_ff;
   logic [CB-1:0]        s2_a_ff  [NUM_AXES];
   logic [PW-1:0]        s2_cm_ff [NUM_AXES], s2_cm_in [NUM_AXES];
   logic [PW-1:0]        s2_cn_ff [NUM_AXES], s2_cn_in [NUM_AXES];
   logic [PW-1:0]        s2_sp_ff [NUM_AXES], s2_sp_in [NUM_AXES];
   logic [PW-1:0]        s2_sq_ff [NUM_AXES], s2_sq_in [NUM_AXES];
   logic [PW-1:0]        s2_sr_ff [NUM_AXES], s2_sr_in [NUM_AXES];

   logic                 s3_valid_ff;
   logic                 s3_last_ff;
   logic [CB-1:0]        s3_a_ff   [NUM_AXES];
   logic [NW-1:0]        s3_n_ff   [NUM_AXES], s3_n_in   [NUM_AXES];
   logic [SW-1:0]        s3_sqs_ff [NUM_AXES], s3_sqs_in [NUM_AXES];

   logic                 s4_valid_ff;
   logic                 s4_last_ff;
   logic [VW-1:0]        s4_vp_ff [NUM_AXES], s4_vp_in [NUM_AXES];
   logic [MW-1:0]        s4_mp_ff [NUM_AXES], s4_mp_in [NUM_AXES];

   logic                 s5_valid_ff;
   term_type             s5_term_ff, s5_term_in;
   logic [VSW-1:0]       vol_sum;

   // whole pipeline moves unless the last stage is blocked by a full queue
   assign adv        = !(s5_valid_ff && q_full);
   assign req_tready = adv;
   assign q_push     = s5_valid_ff && !q_full;
   assign q_term     = s5_term_ff;

   // stage 1: unpack, edges and vertex pair sums
   always_comb begin
      s1_valid_in = req_tvalid;
      for (int i = 0; i < NUM_AXES; i++) begin
         crd_a[i]    = req_tdata[i*CB +: CB];
         crd_b[i]    = req_tdata[(NUM_AXES+i)*CB +: CB];
         crd_c[i]    = req_tdata[(2*NUM_AXES+i)*CB +: CB];
         s1_e1_in[i] = {crd_b[i][CB-1], crd_b[i]} - {crd_a[i][CB-1], crd_a[i]};
         s1_e2_in[i] = {crd_c[i][CB-1], crd_c[i]} - {crd_a[i][CB-1], crd_a[i]};
         s1_p_in[i]  = {crd_a[i][CB-1], crd_a[i]} + {crd_b[i][CB-1], crd_b[i]};
         s1_q_in[i]  = {crd_b[i][CB-1], crd_b[i]} + {crd_c[i][CB-1], crd_c[i]};
         s1_r_in[i]  = {crd_c[i][CB-1], crd_c[i]} + {crd_a[i][CB-1], crd_a[i]};
      end
   end

   // stage 2: cross product partial products and squares
   always_comb begin
      s2_cm_in[0] = emul(s1_e1_ff[1], s1_e2_ff[2]);
      s2_cn_in[0] = emul(s1_e1_ff[2], s1_e2_ff[1]);
      s2_cm_in[1] = emul(s1_e1_ff[2], s1_e2_ff[0]);
      s2_cn_in[1] = emul(s1_e1_ff[0], s1_e2_ff[2]);
      s2_cm_in[2] = emul(s1_e1_ff[0], s1_e2_ff[1]);
      s2_cn_in[2] = emul(s1_e1_ff[1], s1_e2_ff[0]);
      for (int i = 0; i < NUM_AXES; i++) begin
         s2_sp_in[i] = emul(s1_p_ff[i], s1_p_ff[i]);
         s2_sq_in[i] = emul(s1_q_ff[i], s1_q_ff[i]);
         s2_sr_in[i] = emul(s1_r_ff[i], s1_r_ff[i]);
      end
   end

   // stage 3: face vector and sum of squares (squares are never negative)
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         s3_n_in[i]   = {s2_cm_ff[i][PW-1], s2_cm_ff[i]} - {s2_cn_ff[i][PW-1], s2_cn_ff[i]};
         s3_sqs_in[i] = {1'b0, s2_sp_ff[i]} + {1'b0, s2_sq_ff[i]} + {1'b0, s2_sr_ff[i]};
      end
   end

   // stage 4: triple product terms and moment terms
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         s4_vp_in[i] = $signed({{NW{s3_a_ff[i][CB-1]}}, s3_a_ff[i]})
                     * $signed({{CB{s3_n_ff[i][NW-1]}}, s3_n_ff[i]});
         s4_mp_in[i] = $signed({{SW{s3_n_ff[i][NW-1]}}, s3_n_ff[i]})
                     * $signed({{NW{s3_sqs_ff[i][SW-1]}}, s3_sqs_ff[i]});
      end
   end

   // stage 5: sum the triple product and extend to accumulator widths
   always_comb begin
      vol_sum = {{2{s4_vp_ff[0][VW-1]}}, s4_vp_ff[0]}
              + {{2{s4_vp_ff[1][VW-1]}}, s4_vp_ff[1]}
              + {{2{s4_vp_ff[2][VW-1]}}, s4_vp_ff[2]};
      s5_term_in.last = s4_last_ff;
      s5_term_in.vol  = {{(VOL_BITS-VSW){vol_sum[VSW-1]}}, vol_sum};
      for (int i = 0; i < NUM_AXES; i++) begin
         s5_term_in.mom[i] = {{(MOM_BITS-MW){s4_mp_ff[i][MW-1]}}, s4_mp_ff[i]};
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_last_ff <= req_tlast;
         s2_last_ff <= s1_last_ff;
         s3_last_ff <= s2_last_ff;
         s4_last_ff <= s3_last_ff;
         s5_term_ff <= s5_term_in;
         for (int i = 0; i < NUM_AXES; i++) begin
            s1_a_ff[i]   <= crd_a[i];
            s1_e1_ff[i]  <= s1_e1_in[i];
            s1_e2_ff[i]  <= s1_e2_in[i];
            s1_p_ff[i]   <= s1_p_in[i];
            s1_q_ff[i]   <= s1_q_in[i];
            s1_r_ff[i]   <= s1_r_in[i];
            s2_a_ff[i]   <= s1_a_ff[i];
            s2_cm_ff[i]  <= s2_cm_in[i];
            s2_cn_ff[i]  <= s2_cn_in[i];
            s2_sp_ff[i]  <= s2_sp_in[i];
            s2_sq_ff[i]  <= s2_sq_in[i];
            s2_sr_ff[i]  <= s2_sr_in[i];
            s3_a_ff[i]   <= s2_a_ff[i];
            s3_n_ff[i]   <= s3_n_in[i];
            s3_sqs_ff[i] <= s3_sqs_in[i];
            s4_vp_ff[i]  <= s4_vp_in[i];
            s4_mp_ff[i]  <= s4_mp_in[i];
         end
      end
   end

endmodule

[rtl/mvc_fifo.sv]
// mvc_fifo: short queue of per-triangle terms between front pipeline and back
// depends on mvc_pkg and mesh_volume_centroid_defines.svh
`include "mesh_volume_centroid_defines.svh"

module mvc_fifo #(
   parameter int DEPTH = mvc_pkg::MVC_QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mvc_pkg::term_type    push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 pop_valid,
   output mvc_pkg::term_type    pop_data
);
   import mvc_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   term_type        slot_ff [DEPTH];
   logic [AW-1:0]   wptr_ff, wptr_in;
   logic [AW-1:0]   rptr_ff, rptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full      = (count_ff == CW'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = slot_ff[rptr_ff];

   // pointer wrap and fill count
   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == AW'(DEPTH - 1)) ? '0 : wptr_ff + AW'(1);
      end
      if (pop) begin
         rptr_in = (rptr_ff == AW'(DEPTH - 1)) ? '0 : rptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_data;
      end
   end

   `MVC_ASSERT_IMP(a_push_has_room, push, count_ff != CW'(DEPTH), "push into a full queue")
   `MVC_ASSERT_IMP(a_pop_has_entry, pop, count_ff != '0, "pop from an empty queue")

endmodule

[rtl/mvc_back.sv]
// mvc_back: accumulates queued terms and runs the centroid division sequencer
// depends on mvc_pkg and mesh_volume_centroid_defines.svh
`include "mesh_volume_centroid_defines.svh"

module mvc_back (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  logic [mvc_pkg::THR_BITS-1:0]                          min_six_volume,
   input  logic                                                  q_valid,
   input  mvc_pkg::term_type                                     q_data,
   output logic                                                  q_pop,
   output logic                                                  rsp_tvalid,
   input  logic                                                  rsp_tready,
   output logic [mvc_pkg::VOL_BITS-1:0]                          rsp_vol,
   output logic [mvc_pkg::NUM_AXES-1:0][mvc_pkg::CEN_BITS-1:0]   rsp_cen,
   output logic                                                  rsp_small
);
   import mvc_pkg::*;

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_CHECK,
      ST_LOAD,
      ST_START,
      ST_RUN,
      ST_STORE,
      ST_EMIT
   } state_type;

   state_type                          state_ff, state_in;
   logic [VOL_BITS-1:0]                vol_ff, vol_in;
   logic [NUM_AXES-1:0][MOM_BITS-1:0]  mom_ff, mom_in;
   logic [AXIS_W-1:0]                  axis_ff, axis_in;
   logic [MOM_BITS-1:0]                mag_ff, mag_in;
   logic                               neg_ff, neg_in;
   logic                               ovf_ff, ovf_in;
   logic [VOL_BITS-1:0]                rem_ff, rem_in;
   logic [CEN_BITS-1:0]                num_ff, num_in;
   logic [CEN_BITS-1:0]                quo_ff, quo_in;
   logic [STEP_W-1:0]                  step_ff, step_in;
   logic [NUM_AXES-1:0][CEN_BITS-1:0]  cen_ff, cen_in;
   logic                               small_ff, small_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [VOL_BITS-1:0]                rsp_vol_ff, rsp_vol_in;
   logic [NUM_AXES-1:0][CEN_BITS-1:0]  rsp_cen_ff, rsp_cen_in;
   logic                               rsp_small_ff, rsp_small_in;

   logic                               load;
   logic [VOL_BITS-1:0]                min_ext;
   logic [VOL_BITS-1:0]                trial;
   logic [CEN_BITS-1:0]                cen_val;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_vol    = rsp_vol_ff;
   assign rsp_cen    = rsp_cen_ff;
   assign rsp_small  = rsp_small_ff;
   assign min_ext    = {{(VOL_BITS-THR_BITS){1'b0}}, min_six_volume};

   // shift-subtract step: next numerator bit into the partial remainder
   assign trial = {rem_ff[VOL_BITS-2:0], num_ff[CEN_BITS-1]};

   // saturate the quotient magnitude and apply the sign
   always_comb begin
      if (neg_ff) begin
         cen_val = (ovf_ff || quo_ff > CEN_MIN) ? CEN_MIN : ('0 - quo_ff);
      end else begin
         cen_val = (ovf_ff || quo_ff > CEN_MAX) ? CEN_MAX : quo_ff;
      end
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      vol_in       = vol_ff;
      mom_in       = mom_ff;
      axis_in      = axis_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      ovf_in       = ovf_ff;
      rem_in       = rem_ff;
      num_in       = num_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      cen_in       = cen_ff;
      small_in     = small_ff;
      rsp_vol_in   = rsp_vol_ff;
      rsp_cen_in   = rsp_cen_ff;
      rsp_small_in = rsp_small_ff;
      q_pop        = 1'b0;
      load         = 1'b0;
      unique case (state_ff)
         ST_ACCUM: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               vol_in = vol_ff + q_data.vol;
               for (int i = 0; i < NUM_AXES; i++) begin
                  mom_in[i] = mom_ff[i] + q_data.mom[i];
               end
               if (q_data.last) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if ($signed(vol_ff) > $signed(min_ext)) begin
               small_in = 1'b0;
               axis_in  = '0;
               state_in = ST_LOAD;
            end else begin
               small_in = 1'b1;
               cen_in   = '0;
               state_in = ST_EMIT;
            end
         end
         ST_LOAD: begin
            neg_in   = mom_ff[axis_ff][MOM_BITS-1];
            mag_in   = mom_ff[axis_ff][MOM_BITS-1] ? ('0 - mom_ff[axis_ff]) : mom_ff[axis_ff];
            state_in = ST_START;
         end
         ST_START: begin
            // quotient overflows 18 bits when |s| >> 13 already reaches t
            ovf_in   = (mag_ff[MOM_BITS-1:QSHIFT] >= vol_ff[VOL_BITS-2:0]);
            rem_in   = {1'b0, mag_ff[MOM_BITS-1:QSHIFT]};
            num_in   = {mag_ff[QSHIFT-1:0], {FRAC_SHIFT{1'b0}}};
            quo_in   = '0;
            step_in  = STEP_W'(CEN_BITS - 1);
            state_in = ovf_in ? ST_STORE : ST_RUN;
         end
         ST_RUN: begin
            if (trial >= vol_ff) begin
               rem_in = trial - vol_ff;
               quo_in = {quo_ff[CEN_BITS-2:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[CEN_BITS-2:0], 1'b0};
            end
            num_in = {num_ff[CEN_BITS-2:0], 1'b0};
            if (step_ff == '0) begin
               state_in = ST_STORE;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         ST_STORE: begin
            cen_in[axis_ff] = cen_val;
            if (axis_ff == AXIS_LAST) begin
               state_in = ST_EMIT;
            end else begin
               axis_in  = axis_ff + AXIS_W'(1);
               state_in = ST_LOAD;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load         = 1'b1;
               rsp_vol_in   = vol_ff;
               rsp_cen_in   = cen_ff;
               rsp_small_in = small_ff;
               vol_in       = '0;
               mom_in       = '0;
               state_in     = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
      rsp_valid_in = load || (rsp_valid_ff && !rsp_tready);
   end

   // state, accumulators and registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         vol_ff       <= '0;
         mom_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vol_ff       <= vol_in;
         mom_ff       <= mom_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      axis_ff      <= axis_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      ovf_ff       <= ovf_in;
      rem_ff       <= rem_in;
      num_ff       <= num_in;
      quo_ff       <= quo_in;
      step_ff      <= step_in;
      cen_ff       <= cen_in;
      small_ff     <= small_in;
      rsp_vol_ff   <= rsp_vol_in;
      rsp_cen_ff   <= rsp_cen_in;
      rsp_small_ff <= rsp_small_in;
   end

   `MVC_ASSERT_IMP(a_rem_below_divisor, state_ff == ST_RUN, rem_ff < vol_ff, "division remainder not below divisor")
   `MVC_ASSERT_NEXT(a_sums_cleared, load, vol_ff == '0 && mom_ff == '0, "sums not cleared after result")
   `MVC_ASSERT_IMP(a_small_means_zero, rsp_valid_ff && rsp_small_ff, rsp_cen_ff == '0, "centroid not zero on small volume")

endmodule

[rtl/mesh_volume_centroid.sv]
// Mesh volume and centroid. Triangles stream in on req_ one per transfer, one per cycle while
// nothing stalls; each passes a five-stage front pipeline that forms the face vector, the
// triple product and the per-axis moment terms, and lands in a short queue. The back end
// adds one queued triangle per cycle, while it is accumulating, into 48-bit volume and
// 60-bit moment sums. After the triangle marked last, a shared shift-subtract divider
// produces the three centroid coordinates at one quotient bit per cycle: a volume check,
// then per axis a load and a start state, 18 division steps and a store, then the result is
// registered. When the volume is too small the division is skipped and the result is
// registered with zero centroids. An axis whose quotient overflows skips its 18 steps. A
// result still held on rsp_ delays the registering of the next one. During the division and
// that wait the queue and pipeline absorb up to nine triangles of the next mesh before
// req_tready drops. The threshold register on csr_ is taken in any cycle; write it
// between meshes.
// depends on mvc_pkg, mvc_front, mvc_fifo, mvc_back
module mesh_volume_centroid #(
   parameter int COORD_BITS  = mvc_pkg::MVC_COORD_BITS,
   parameter int QUEUE_DEPTH = mvc_pkg::MVC_QUEUE_DEPTH
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // triangle stream
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from the lowest bit up
   input  logic [((mvc_pkg::NUM_COORDS*COORD_BITS+7)/8)*8-1:0] req_tdata,
   input  logic                                    req_tlast,
   // result stream
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // six_volume, center_x, center_y, center_z from the lowest bit up
   output logic [mvc_pkg::OUT_DATA_W-1:0]          rsp_tdata,
   // too_small
   output logic                                    rsp_tuser,
   // threshold register write
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [mvc_pkg::THR_BITS-1:0]            csr_data
);
   import mvc_pkg::*;

   logic [THR_BITS-1:0]                 thr_ff, thr_in;
   logic                                q_full;
   logic                                q_push;
   term_type                            q_term;
   logic                                q_valid;
   logic                                q_pop;
   term_type                            q_head;
   logic [VOL_BITS-1:0]                 rsp_vol;
   logic [NUM_AXES-1:0][CEN_BITS-1:0]   rsp_cen;

   // threshold register, written on any csr transfer
   assign csr_ready = 1'b1;
   assign thr_in    = csr_valid ? csr_data : thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else begin
         thr_ff <= thr_in;
      end
   end

   mvc_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_term     (q_term)
   );

   mvc_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_term),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_head)
   );

   mvc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .min_six_volume (thr_ff),
      .q_valid        (q_valid),
      .q_data         (q_head),
      .q_pop          (q_pop),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_vol        (rsp_vol),
      .rsp_cen        (rsp_cen),
      .rsp_small      (rsp_tuser)
   );

   // result packing, zero fill up to whole bytes
   assign rsp_tdata = {{(OUT_DATA_W-OUT_FIELD_W){1'b0}}, rsp_cen[2], rsp_cen[1], rsp_cen[0],
                       rsp_vol};

endmodule
